>>> rtl/longest_distinct_run_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Longest distinct run tracker - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_DISTINCT_RUN_TRACKER_TOP_MACROS_SVH
`define LONGEST_DISTINCT_RUN_TRACKER_TOP_MACROS_SVH

// Same-cycle implication
`define LDRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LDRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ldrt_pkg.sv
// ----------------------------------------------------------------------------
// ldrt_pkg
// Shared widths and defaults of the longest distinct run tracker.
// ----------------------------------------------------------------------------
package ldrt_pkg;

  // Field widths
  localparam int SYM_W       = 7;
  localparam int OUT_W       = 17;
  localparam int SYM_CODES   = 1 << SYM_W;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Parameter defaults
  localparam int DEF_ALPHABET_SIZE = 128;
  localparam int DEF_MAX_LEN       = 65536;

endpackage

>>> rtl/ldrt_pos_mem.sv
// ----------------------------------------------------------------------------
// ldrt_pos_mem
// Last-seen position table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ldrt_pos_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read when rd_en is set, hold otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/longest_distinct_run_tracker_top.sv
// ----------------------------------------------------------------------------
// An accepted input item goes through the stage-1 and output registers to out_tvalid.
// Throughput: 1 item per cycle without output stall; set by the position table's single
//   read-modify-write per item, with the write forwarded to the next read.
// Reset: synchronous rst_n clears the valid marks, window start, position,
//   best length and the pipeline at once; the position table is not cleared.
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker_top
// Tracks the longest run without a repeated character, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module longest_distinct_run_tracker_top #(
  parameter int ALPHABET_SIZE = ldrt_pkg::DEF_ALPHABET_SIZE,
  parameter int MAX_LEN       = ldrt_pkg::DEF_MAX_LEN
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ldrt_pkg::IN_TDATA_W-1:0]  in_tdata,   // [6:0] symbol, [7] zero
  input  logic                             in_tlast,   // last_symbol
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ldrt_pkg::OUT_TDATA_W-1:0] out_tdata,  // [16:0] run_length,
                                                       // [33:17] best_length, [39:34] zero
  output logic                             out_tlast,  // string_done
  output logic [0:0]                       out_tuser   // [0] dropped
);

  import ldrt_pkg::*;

  localparam int IDX_W   = $clog2(ALPHABET_SIZE);
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int STORE_W = $clog2(MAX_LEN);

  // Code reduction table
  logic [IDX_W-1:0] code_map [SYM_CODES];
  logic [IDX_W-1:0] in_code;

  for (genvar g = 0; g < SYM_CODES; g++) begin : g_code_map
    assign code_map[g] = IDX_W'(g % ALPHABET_SIZE);
  end

  assign in_code = code_map[in_tdata[SYM_W-1:0]];

  // Handshake
  logic out_free;
  logic s1_fire;
  logic in_acc;

  logic               s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]   s1_code_r;
  logic               s1_last_r;
  logic               fwd_hit_r;
  logic [STORE_W-1:0] fwd_pos_r;

  logic [POS_W-1:0]         ws_r, ws_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [POS_W-1:0]         best_r, best_nxt;
  logic [ALPHABET_SIZE-1:0] seen_r, seen_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0] out_run_r;
  logic [OUT_W-1:0] out_best_r;
  logic             out_last_r;
  logic             out_drop_r;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_fire   = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || s1_fire;
  assign in_acc    = in_tvalid && in_tready;

  // Position table
  logic [STORE_W-1:0] rd_data;
  logic               wr_en;
  logic [STORE_W-1:0] wr_data;

  ldrt_pos_mem #(
    .DEPTH  (ALPHABET_SIZE),
    .ADDR_W (IDX_W),
    .DATA_W (STORE_W)
  ) u_pos_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_code),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_code_r),
    .wr_data (wr_data)
  );

  // Window update for the item in stage 1
  logic               drop;
  logic [STORE_W-1:0] prev_pos;
  logic               prev_in;
  logic [POS_W-1:0]   ws_upd;
  logic [POS_W-1:0]   run_acc;
  logic [POS_W-1:0]   run;
  logic [POS_W-1:0]   best_upd;
  logic [POS_W-1:0]   best_out;

  assign drop     = pos_r >= POS_W'(MAX_LEN);
  assign prev_pos = fwd_hit_r ? fwd_pos_r : rd_data;
  assign prev_in  = seen_r[s1_code_r] && (POS_W'(prev_pos) >= ws_r);
  assign ws_upd   = prev_in ? POS_W'(prev_pos) + POS_W'(1) : ws_r;
  assign run_acc  = pos_r - ws_upd + POS_W'(1);
  assign run      = drop ? (pos_r - ws_r) : run_acc;
  assign best_upd = (run_acc > best_r) ? run_acc : best_r;
  assign best_out = drop ? best_r : best_upd;

  assign wr_en   = s1_fire && !drop;
  assign wr_data = STORE_W'(pos_r);

  // Advance string state
  always_comb begin
    ws_nxt   = ws_r;
    pos_nxt  = pos_r;
    best_nxt = best_r;
    seen_nxt = seen_r;
    if (s1_fire) begin
      if (!drop) begin
        ws_nxt              = ws_upd;
        pos_nxt             = pos_r + POS_W'(1);
        best_nxt            = best_upd;
        seen_nxt[s1_code_r] = 1'b1;
      end
      if (s1_last_r) begin
        ws_nxt   = '0;
        pos_nxt  = '0;
        best_nxt = '0;
        seen_nxt = '0;
      end
    end
  end

  // Stage and output valids
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ws_r      <= '0;
      pos_r     <= '0;
      best_r    <= '0;
      seen_r    <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      ws_r      <= ws_nxt;
      pos_r     <= pos_nxt;
      best_r    <= best_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // Capture the item and forward a same-edge table write
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_code_r <= in_code;
      s1_last_r <= in_tlast;
      fwd_hit_r <= wr_en && (s1_code_r == in_code);
      fwd_pos_r <= wr_data;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_run_r  <= OUT_W'(run);
      out_best_r <= OUT_W'(best_out);
      out_last_r <= s1_last_r;
      out_drop_r <= drop;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 * OUT_W){1'b0}}, out_best_r, out_run_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

endmodule

>>> rtl/ldrt_checker.sv
// ----------------------------------------------------------------------------
// ldrt_checker
// Port-level checks of the longest distinct run tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "longest_distinct_run_tracker_top_macros.svh"

module ldrt_checker #(
  parameter int MAX_LEN = ldrt_pkg::DEF_MAX_LEN
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ldrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic [0:0]                       out_tuser
);

  import ldrt_pkg::*;

  // Lengths stay below the field's wrap point
  localparam bit NO_WRAP = MAX_LEN < (1 << OUT_W);

  logic             out_acc;
  logic [OUT_W-1:0] run;
  logic [OUT_W-1:0] best;
  logic             after_last_r;
  logic [OUT_W-1:0] prev_best_r;

  assign out_acc = out_tvalid && out_tready;
  assign run     = out_tdata[OUT_W-1:0];
  assign best    = out_tdata[2*OUT_W-1:OUT_W];

  // Track string boundaries and the last best length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_last_r <= 1'b1;
      prev_best_r  <= '0;
    end else if (out_acc) begin
      after_last_r <= out_tlast;
      prev_best_r  <= best;
    end
  end

  `LDRT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result item changed")
  `LDRT_ASSERT_IMP(a_first_item, out_acc && after_last_r, run == OUT_W'(1) && best == OUT_W'(1) && !out_tuser[0], "first item of a string must give unit lengths")
  `LDRT_ASSERT_IMP(a_best_rises, out_acc && !after_last_r && NO_WRAP, best >= prev_best_r, "best length fell within a string")
  `LDRT_ASSERT_IMP(a_run_in_best, out_acc && NO_WRAP, run <= best, "run length exceeds best length")

endmodule

bind longest_distinct_run_tracker_top ldrt_checker #(.MAX_LEN(MAX_LEN)) u_ldrt_checker (.*);
